// ===== rtl/core/lnpa_pkg.sv =====
// shared types, codes and constants for the linked node pool allocator
package lnpa_pkg;

    localparam int HANDLE_W     = 12;
    localparam int FRESH_W      = 13;
    localparam int COUNT_W      = 16;
    localparam int LINK_DEPTH   = 4096;
    localparam int CAPACITY_DEF = 4096;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] node_handle;
    } req_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]       allocated_handle;
        logic                      was_active;
        logic signed [COUNT_W-1:0] live_count;
        logic [1:0]                status;
    } rsp_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_POP,
        S_ALLOC_PUSH,
        S_WALK_CHECK,
        S_WALK_NEXT,
        S_UNLINK,
        S_FREE_PUSH,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic read_free;
        logic pop_free;
        logic alloc_fresh;
        logic push_active;
        logic set_exhausted;
        logic set_bad;
        logic walk_start;
        logic read_cur;
        logic step_prev;
        logic walk_load;
        logic unlink;
        logic push_free;
        logic wipe_pool;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       handle_zero;
        logic       free_empty;
        logic       fresh_exhausted;
        logic       walk_end;
        logic       walk_hit;
        logic       prev_zero;
    } dp_status_t;

endpackage

// ===== rtl/core/lnpa_datapath.sv =====
// datapath: list heads, counters, walk registers, shared next-link memory, result register
module lnpa_datapath #(
    parameter int CAPACITY = lnpa_pkg::CAPACITY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lnpa_pkg::req_item_t   req_item,
    input  lnpa_pkg::cmd_t        cmd,
    output lnpa_pkg::dp_status_t  stat,
    output lnpa_pkg::rsp_item_t   rsp_item
);

    localparam int HW          = lnpa_pkg::HANDLE_W;
    localparam int FW          = lnpa_pkg::FRESH_W;
    localparam int CW          = lnpa_pkg::COUNT_W;
    localparam int STEP_W      = $clog2(CAPACITY + 1);
    localparam int FRESH_LIMIT = (CAPACITY < lnpa_pkg::LINK_DEPTH) ? CAPACITY
                                                                   : lnpa_pkg::LINK_DEPTH;

    // architectural state
    logic [HW-1:0] active_head_reg;
    logic [HW-1:0] avail_head_reg;
    logic [FW-1:0] fresh_reg;
    logic [CW-1:0] live_reg;

    // per-item working registers
    logic [1:0]        opcode_reg;
    logic [HW-1:0]     handle_reg;
    logic [HW-1:0]     node_reg;
    logic [HW-1:0]     cur_reg;
    logic [HW-1:0]     prev_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [HW-1:0]     given_reg;
    logic              found_reg;
    logic [1:0]        status_reg;
    lnpa_pkg::rsp_item_t out_reg;

    // next-link memory
    logic [HW-1:0] link_mem [lnpa_pkg::LINK_DEPTH];
    logic [HW-1:0] rdata_reg;
    logic          we;
    logic [HW-1:0] waddr;
    logic [HW-1:0] wdata;
    logic          re;
    logic [HW-1:0] raddr;

    always_comb
    begin
        we    = 1'b0;
        waddr = node_reg;
        wdata = active_head_reg;
        if (cmd.push_active)
        begin
            we = 1'b1;
        end
        else if (cmd.unlink && (prev_reg != '0))
        begin
            we    = 1'b1;
            waddr = prev_reg;
            wdata = rdata_reg;
        end
        else if (cmd.push_free)
        begin
            we    = 1'b1;
            waddr = handle_reg;
            wdata = avail_head_reg;
        end
    end

    assign re    = cmd.read_free | cmd.read_cur;
    assign raddr = cmd.read_free ? avail_head_reg : cur_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= link_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_head_reg <= '0;
            avail_head_reg  <= '0;
            fresh_reg       <= FW'(1);
            live_reg        <= '0;
        end
        else
        begin
            if (cmd.wipe_pool)
            begin
                active_head_reg <= '0;
                avail_head_reg  <= '0;
                fresh_reg       <= FW'(1);
                live_reg        <= '0;
            end
            if (cmd.alloc_fresh)
            begin
                fresh_reg <= fresh_reg + FW'(1);
            end
            if (cmd.pop_free)
            begin
                avail_head_reg <= rdata_reg;
            end
            if (cmd.push_active)
            begin
                active_head_reg <= node_reg;
                live_reg        <= live_reg + CW'(1);
            end
            if (cmd.unlink && (prev_reg == '0))
            begin
                active_head_reg <= rdata_reg;
            end
            if (cmd.push_free)
            begin
                avail_head_reg <= handle_reg;
                live_reg       <= live_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            opcode_reg <= req_item.opcode;
            handle_reg <= req_item.node_handle;
            given_reg  <= '0;
            found_reg  <= 1'b0;
            status_reg <= lnpa_pkg::ST_OK;
        end
        if (cmd.read_free)
        begin
            node_reg <= avail_head_reg;
        end
        if (cmd.alloc_fresh)
        begin
            node_reg <= fresh_reg[HW-1:0];
        end
        if (cmd.push_active)
        begin
            given_reg <= node_reg;
        end
        if (cmd.set_exhausted)
        begin
            status_reg <= lnpa_pkg::ST_EXHAUSTED;
        end
        if (cmd.set_bad)
        begin
            status_reg <= lnpa_pkg::ST_BAD_HANDLE;
        end
        if (cmd.walk_start)
        begin
            prev_reg  <= '0;
            cur_reg   <= active_head_reg;
            steps_reg <= '0;
        end
        if (cmd.step_prev)
        begin
            prev_reg  <= cur_reg;
            steps_reg <= steps_reg + STEP_W'(1);
        end
        if (cmd.walk_load)
        begin
            cur_reg <= rdata_reg;
        end
        if (cmd.unlink)
        begin
            found_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_reg.allocated_handle <= given_reg;
            out_reg.was_active       <= found_reg;
            out_reg.live_count       <= $signed(live_reg);
            out_reg.status           <= status_reg;
        end
    end

    always_comb
    begin
        stat.opcode          = opcode_reg;
        stat.handle_zero     = (handle_reg == '0);
        stat.free_empty      = (avail_head_reg == '0);
        stat.fresh_exhausted = (fresh_reg >= FW'(FRESH_LIMIT));
        stat.walk_end        = (cur_reg == '0) || (steps_reg >= STEP_W'(CAPACITY));
        stat.walk_hit        = (cur_reg == handle_reg);
        stat.prev_zero       = (prev_reg == '0);
    end

    assign rsp_item = out_reg;

endmodule

// ===== rtl/core/lnpa_ctrl.sv =====
// controller: sequencing state machine and result valid flag
module lnpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  lnpa_pkg::dp_status_t stat,
    output lnpa_pkg::cmd_t       cmd
);

    lnpa_pkg::state_t state_reg;
    lnpa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lnpa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lnpa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lnpa_pkg::S_DECODE;
                end
            end
            lnpa_pkg::S_DECODE:
            begin
                unique case (stat.opcode)
                    lnpa_pkg::OP_ALLOC:
                    begin
                        if (!stat.free_empty)
                        begin
                            state_next = lnpa_pkg::S_ALLOC_POP;
                        end
                        else if (stat.fresh_exhausted)
                        begin
                            state_next = lnpa_pkg::S_FINISH;
                        end
                        else
                        begin
                            state_next = lnpa_pkg::S_ALLOC_PUSH;
                        end
                    end
                    lnpa_pkg::OP_FREE:
                    begin
                        state_next = stat.handle_zero ? lnpa_pkg::S_FINISH
                                                      : lnpa_pkg::S_WALK_CHECK;
                    end
                    default:
                    begin
                        state_next = lnpa_pkg::S_FINISH;
                    end
                endcase
            end
            lnpa_pkg::S_ALLOC_POP:  state_next = lnpa_pkg::S_ALLOC_PUSH;
            lnpa_pkg::S_ALLOC_PUSH: state_next = lnpa_pkg::S_FINISH;
            lnpa_pkg::S_WALK_CHECK:
            begin
                if (stat.walk_end)
                begin
                    state_next = lnpa_pkg::S_FREE_PUSH;
                end
                else if (stat.walk_hit)
                begin
                    state_next = lnpa_pkg::S_UNLINK;
                end
                else
                begin
                    state_next = lnpa_pkg::S_WALK_NEXT;
                end
            end
            lnpa_pkg::S_WALK_NEXT:  state_next = lnpa_pkg::S_WALK_CHECK;
            lnpa_pkg::S_UNLINK:     state_next = lnpa_pkg::S_FREE_PUSH;
            lnpa_pkg::S_FREE_PUSH:  state_next = lnpa_pkg::S_FINISH;
            lnpa_pkg::S_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    state_next = lnpa_pkg::S_IDLE;
                end
            end
            default:                state_next = lnpa_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            lnpa_pkg::S_IDLE:
            begin
                cmd.latch_in = req_valid;
            end
            lnpa_pkg::S_DECODE:
            begin
                unique case (stat.opcode)
                    lnpa_pkg::OP_ALLOC:
                    begin
                        if (!stat.free_empty)
                        begin
                            cmd.read_free = 1'b1;
                        end
                        else if (stat.fresh_exhausted)
                        begin
                            cmd.set_exhausted = 1'b1;
                        end
                        else
                        begin
                            cmd.alloc_fresh = 1'b1;
                        end
                    end
                    lnpa_pkg::OP_FREE:
                    begin
                        cmd.set_bad    = stat.handle_zero;
                        cmd.walk_start = !stat.handle_zero;
                    end
                    lnpa_pkg::OP_RESET:
                    begin
                        cmd.wipe_pool = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            lnpa_pkg::S_ALLOC_POP:  cmd.pop_free    = 1'b1;
            lnpa_pkg::S_ALLOC_PUSH: cmd.push_active = 1'b1;
            lnpa_pkg::S_WALK_CHECK:
            begin
                if (!stat.walk_end)
                begin
                    cmd.read_cur  = 1'b1;
                    cmd.step_prev = !stat.walk_hit;
                end
            end
            lnpa_pkg::S_WALK_NEXT:  cmd.walk_load = 1'b1;
            lnpa_pkg::S_UNLINK:     cmd.unlink    = 1'b1;
            lnpa_pkg::S_FREE_PUSH:  cmd.push_free = 1'b1;
            lnpa_pkg::S_FINISH:
            begin
                cmd.load_out = !out_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign req_ready = (state_reg == lnpa_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;

    // result register is never overwritten while a result is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp_ready))
        else $error("result overwritten before it was taken");

    // at most one memory write source in any cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push_active, cmd.unlink && !stat.prev_zero, cmd.push_free}))
        else $error("conflicting next-link writes");

    // a loaded link always follows a read issued in the walk check
    a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lnpa_pkg::S_WALK_NEXT || state_reg == lnpa_pkg::S_UNLINK)
        |-> $past(cmd.read_cur))
        else $error("link used without a preceding read");

    // an accepted item always moves straight into decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == lnpa_pkg::S_DECODE))
        else $error("accepted item not decoded");

endmodule

// ===== rtl/core/linked_node_pool_allocator.sv =====
// top level of the linked node pool allocator: controller plus datapath
//
// Node pool handing out handles 1..CAPACITY-1 (never above 4095); handle 0
// means none. One item is processed at a time. Allocate pops the free list
// when it is not empty (one registered read of the next-link memory, then
// the pop and the push onto the active list), else takes a fresh handle, else
// reports the pool exhausted. Reset-pool, the unused opcode and a free of
// handle 0 go straight from decode to the result. A free walks the active
// list through the single read port of the next-link memory, each link passed
// taking a read, then a load, until the node is met or the walk ends (links
// passed capped at CAPACITY). A result waits in an output register; the next
// item is accepted in the cycle after the result is loaded, even while that
// result is not taken yet. The next-link memory is never cleared: only entries
// that were written are ever followed.
module linked_node_pool_allocator #(
    parameter int CAPACITY = lnpa_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lnpa_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lnpa_pkg::rsp_item_t rsp_item
);

    // command and status bundles between the two halves
    lnpa_pkg::cmd_t       cmd;
    lnpa_pkg::dp_status_t stat;

    // sequencing: one state per memory access or list update
    lnpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // list heads, counters, walk pointers and the shared next-link memory
    lnpa_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_item (req_item),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_item (rsp_item)
    );

endmodule
